>>> rtl/bblur_pkg.sv
// ----------------------------------------------------------------------------
// bblur_pkg
// Types, constants and the rounded mean shared by the 3x3 box blur block.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int CFG_DW = 13;
  localparam int CFG_IW = 1;

  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam int FRAME_WIDTH_RESET  = 640;
  localparam int FRAME_HEIGHT_RESET = 480;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // reciprocals for exact floor division of values below 2^12
  localparam logic [12:0] RECIP3       = 13'd5462;
  localparam logic [4:0]  RECIP3_SHIFT = 5'd14;
  localparam logic [12:0] RECIP9       = 13'd7282;
  localparam logic [4:0]  RECIP9_SHIFT = 5'd16;

  typedef struct packed {
    logic       func;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       end_of_frame;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
    logic row_top;
    logic row_bot;
    logic col_left;
    logic col_right;
    logic last;
  } win_ctl_t;

  typedef struct packed {
    logic [11:0] red;
    logic [11:0] green;
    logic [11:0] blue;
    logic [3:0]  n;
    logic        last;
  } sum_t;

  // (2*sum + n) / (2*n), n in {1,2,3,4,6,9}
  function automatic logic [7:0] rounded_mean(logic [11:0] s, logic [3:0] n);
    logic [12:0] t;
    logic [11:0] u;
    logic [12:0] m;
    logic [4:0]  k;
    logic [24:0] p;
    t = {s, 1'b0} + 13'(n);
    unique case (n)
      4'd1: begin
        u = t[12:1];        m = 13'd1;  k = 5'd0;
      end
      4'd2: begin
        u = 12'(t >> 2);    m = 13'd1;  k = 5'd0;
      end
      4'd3: begin
        u = t[12:1];        m = RECIP3; k = RECIP3_SHIFT;
      end
      4'd4: begin
        u = 12'(t >> 3);    m = 13'd1;  k = 5'd0;
      end
      4'd6: begin
        u = 12'(t >> 2);    m = RECIP3; k = RECIP3_SHIFT;
      end
      4'd9: begin
        u = t[12:1];        m = RECIP9; k = RECIP9_SHIFT;
      end
      default: begin
        u = t[12:1];        m = 13'd1;  k = 5'd0;
      end
    endcase
    p = 25'(u) * 25'(m);
    return 8'(p >> k);
  endfunction

endpackage

>>> rtl/box_blur_3x3_stream_unit.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_unit
// 3x3 box blur over a raster RGB stream with two line RAMs and a window.
// Pacing: an item is taken only in the idle state, so it waits for the line
//   RAM read-modify-write of the previous item and, if that one yields a
//   result, its sum and divide stages; divide holds while the output is
//   stalled, and an early drain is ignored. A result enters the output
//   register in the divide state; it belongs to the pixel frame_width+1 items earlier.
// Reset: sync, clears window, positions and the output valid; line RAMs are
//   not cleared (unwritten entries only feed masked neighbors).
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_unit
  import bblur_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_stall,
  input  pix_in_t           pix,
  output logic              res_valid,
  input  logic              res_stall,
  output pix_out_t          res,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int W_RST = (FRAME_WIDTH_RESET  > MAX_WIDTH)  ? MAX_WIDTH  : FRAME_WIDTH_RESET;
  localparam int H_RST = (FRAME_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RESET;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_SUM, S_DIV} state_t;

  state_t        state;
  logic [WW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [CW-1:0] out_col;
  logic [RW-1:0] out_row;
  logic          done;
  logic          item_drain;
  rgb_t          item_pix;

  logic          take;
  logic          restart_in;
  logic [CW-1:0] rd_addr;
  logic          col_end;
  logic          due;
  logic          out_row_end;
  logic          out_col_end;
  logic          sum_last;
  logic          ram_we;
  logic [23:0]   upper_rd;
  logic [23:0]   lower_rd;
  rgb_t          bot_px;
  win_ctl_t      ctl;
  sum_t          sums;
  logic          mean_ready;
  logic          mean_load;

  function automatic logic [WW-1:0] clamp_w(logic [10:0] v);
    logic [WW-1:0] r;
    if (v == '0) begin
      r = WW'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      r = WW'(MAX_WIDTH);
    end else begin
      r = WW'(v);
    end
    return r;
  endfunction

  function automatic logic [RW-1:0] clamp_h(logic [12:0] v);
    logic [RW-1:0] r;
    if (v == '0) begin
      r = RW'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      r = RW'(MAX_HEIGHT);
    end else begin
      r = RW'(v);
    end
    return r;
  endfunction

  assign pix_stall  = (state != S_IDLE);
  // drains count only once the frame's pixels are all in
  assign take       = pix_valid && !pix_stall && !cfg_write
                      && ((pix.func == FUNC_PIXEL) || done);
  assign restart_in = take && (pix.func == FUNC_PIXEL) && done;
  assign rd_addr    = restart_in ? '0 : in_col;

  assign col_end     = (WW'(in_col) + WW'(1)) >= eff_w;
  assign due         = (in_row > RW'(1)) || ((in_row == RW'(1)) && (in_col != '0));
  assign out_row_end = (out_row + RW'(1)) >= eff_h;
  assign out_col_end = (WW'(out_col) + WW'(1)) >= eff_w;
  assign sum_last    = out_row_end && out_col_end;

  assign ram_we    = (state == S_READ) && !item_drain;
  assign bot_px    = item_drain ? '0 : item_pix;
  assign mean_load = (state == S_DIV) && mean_ready;

  always_comb begin
    ctl.shift     = (state == S_READ);
    ctl.clear     = cfg_write || restart_in || ((state == S_SUM) && sum_last);
    ctl.load      = (state == S_SUM);
    ctl.row_top   = (out_row != '0);
    ctl.row_bot   = !out_row_end;
    ctl.col_left  = (out_col != '0);
    ctl.col_right = !out_col_end;
    ctl.last      = sum_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      eff_w   <= WW'(W_RST);
      eff_h   <= RW'(H_RST);
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      done    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  eff_w <= clamp_w(cfg_data[10:0]);
        REG_FRAME_HEIGHT: eff_h <= clamp_h(cfg_data[12:0]);
      endcase
      state   <= S_IDLE;
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      done    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            item_drain <= (pix.func == FUNC_DRAIN);
            item_pix   <= '{r: pix.in_red, g: pix.in_green, b: pix.in_blue};
            if (restart_in) begin
              in_col  <= '0;
              in_row  <= '0;
              out_col <= '0;
              out_row <= '0;
              done    <= 1'b0;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          if (col_end) begin
            in_col <= '0;
            in_row <= in_row + RW'(1);
            if (!item_drain && ((in_row + RW'(1)) >= eff_h)) begin
              done <= 1'b1;
            end
          end else begin
            in_col <= in_col + CW'(1);
          end
          state <= due ? S_SUM : S_IDLE;
        end
        S_SUM: begin
          if (sum_last) begin
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
            done    <= 1'b0;
          end else if (out_col_end) begin
            out_col <= '0;
            out_row <= out_row + RW'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (mean_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // upper[x] takes the old lower[x], lower[x] takes the new pixel
  bblur_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_col),
    .wdata (lower_rd),
    .raddr (rd_addr),
    .rdata (upper_rd)
  );

  bblur_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_lower_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_col),
    .wdata (item_pix),
    .raddr (rd_addr),
    .rdata (lower_rd)
  );

  bblur_window u_window (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .top_px (rgb_t'(upper_rd)),
    .mid_px (rgb_t'(lower_rd)),
    .bot_px (bot_px),
    .sums   (sums)
  );

  bblur_mean u_mean (
    .clk       (clk),
    .rst       (rst),
    .sums      (sums),
    .load      (mean_load),
    .ready     (mean_ready),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

>>> rtl/bblur_ram.sv
// ----------------------------------------------------------------------------
// bblur_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bblur_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bblur_window.sv
// ----------------------------------------------------------------------------
// bblur_window
// 3x3 pixel window with column shift, and the masked per-channel sums.
// ----------------------------------------------------------------------------
module bblur_window
  import bblur_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  win_ctl_t ctl,
  input  rgb_t     top_px,
  input  rgb_t     mid_px,
  input  rgb_t     bot_px,
  output sum_t     sums
);

  rgb_t win [9];
  rgb_t col_in [3];
  logic row_ok [3];
  logic col_ok [3];
  sum_t sum_c;

  assign col_in[0] = top_px;
  assign col_in[1] = mid_px;
  assign col_in[2] = bot_px;

  assign row_ok[0] = ctl.row_top;
  assign row_ok[1] = 1'b1;
  assign row_ok[2] = ctl.row_bot;
  assign col_ok[0] = ctl.col_left;
  assign col_ok[1] = 1'b1;
  assign col_ok[2] = ctl.col_right;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (ctl.shift) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3 + 0] <= win[k*3 + 1];
        win[k*3 + 1] <= win[k*3 + 2];
        win[k*3 + 2] <= col_in[k];
      end
    end
  end

  always_comb begin
    sum_c = '0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        if (row_ok[dr] && col_ok[dc]) begin
          sum_c.red   = sum_c.red   + 12'(win[dr*3 + dc].r);
          sum_c.green = sum_c.green + 12'(win[dr*3 + dc].g);
          sum_c.blue  = sum_c.blue  + 12'(win[dr*3 + dc].b);
          sum_c.n     = sum_c.n + 4'd1;
        end
      end
    end
    sum_c.last = ctl.last;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sums <= sum_c;
    end
  end

endmodule

>>> rtl/bblur_mean.sv
// ----------------------------------------------------------------------------
// bblur_mean
// Rounded mean per channel and the result output register.
// ----------------------------------------------------------------------------
module bblur_mean
  import bblur_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  sum_t     sums,
  input  logic     load,
  output logic     ready,
  output logic     res_valid,
  input  logic     res_stall,
  output pix_out_t res
);

  assign ready = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.out_red      <= rounded_mean(sums.red,   sums.n);
      res.out_green    <= rounded_mean(sums.green, sums.n);
      res.out_blue     <= rounded_mean(sums.blue,  sums.n);
      res.end_of_frame <= sums.last;
    end
  end

endmodule

>>> rtl/bblur_checker.sv
// ----------------------------------------------------------------------------
// bblur_checker
// Port-level checks on the box blur block, bound to its top level.
// ----------------------------------------------------------------------------
module bblur_checker
  import bblur_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     pix_valid,
  input logic     pix_stall,
  input pix_in_t  pix,
  input logic     res_valid,
  input logic     res_stall,
  input pix_out_t res,
  input logic     cfg_write
);

  // held result stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // an accepted pixel always goes through the line RAM read before the next item
  a_pix_busy: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_stall && (pix.func == FUNC_PIXEL) && !cfg_write |=> pix_stall)
    else $error("pixel item did not occupy the block");

  // a new result is only loaded from the divide stage, while input is held off
  a_res_load: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pix_stall))
    else $error("result appeared without a busy cycle");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind box_blur_3x3_stream_unit bblur_checker u_bblur_checker (.*);
